// ===== hdl/tanh_pkg.sv =====
// shared types and constants for the tanh activation unit
`default_nettype none
package tanh_pkg;

   localparam int X_W    = 16;
   localparam int MAG_W  = 17;
   localparam int S_W    = 23;
   localparam int Q_W    = 29;
   localparam int C_W    = 35;
   localparam int NUM_W  = 39;
   localparam int DEN_W  = 41;
   localparam int PROD_W = MAG_W + NUM_W;
   localparam int REM_W  = 58;
   localparam int DIVR_W = DEN_W + 1;
   localparam int QUO_W  = 16;
   localparam int R_W    = 15;
   localparam int SQ_W   = 17;
   localparam int THR_W  = 15;
   localparam int MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_TANH    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DERIV_X = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DERIV_V = 2'd2;

   localparam logic [2:0] ADDR_MODE = 3'd0;
   localparam logic [2:0] ADDR_THR  = 3'd4;

   localparam logic [THR_W-1:0] THR_RESET = 15'd20070;

   localparam logic [NUM_W-1:0] PADE_K0   = NUM_W'(64'd135135 << 16);
   localparam logic [15:0]      PADE_N2   = 16'd17325;
   localparam logic [15:0]      PADE_N4   = 16'd378;
   localparam logic [15:0]      PADE_D2   = 16'd62370;
   localparam logic [15:0]      PADE_D4   = 16'd3150;
   localparam logic [15:0]      PADE_D6   = 16'd28;
   localparam logic [R_W-1:0]   ONE_Q14   = 15'd16384;

   // side information carried alongside each sample
   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic                  neg;
      logic                  forced;
      logic                  xzero;
      logic signed [X_W-1:0] x;
   } tag_type;

endpackage
`default_nettype wire

// ===== hdl/tanh_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module tanh_divider (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              adv,
   input  wire                              in_valid,
   input  wire [tanh_pkg::REM_W-1:0]        in_dividend,
   input  wire [tanh_pkg::DIVR_W-1:0]       in_divisor,
   input  wire tanh_pkg::tag_type           in_tag,
   output logic                             out_valid,
   output logic [tanh_pkg::QUO_W-1:0]       out_quo,
   output logic                             out_ovf,
   output tanh_pkg::tag_type                out_tag
);

   localparam int NST = tanh_pkg::QUO_W + 1;

   logic [NST-1:0]                 v_ff;
   logic [tanh_pkg::REM_W-1:0]     rem_ff [NST];
   logic [tanh_pkg::DIVR_W-1:0]    div_ff [NST];
   logic [tanh_pkg::QUO_W-1:0]     quo_ff [NST];
   logic                           ovf_ff [NST];
   tanh_pkg::tag_type              tag_ff [NST];

   logic [tanh_pkg::REM_W-1:0]     rem_in [NST];
   logic [tanh_pkg::QUO_W-1:0]     quo_in [NST];
   logic                           ovf_in;

   // quotient must fit in QUO_W bits
   assign ovf_in = in_dividend >=
      (tanh_pkg::REM_W'(in_divisor) << tanh_pkg::QUO_W);
   assign rem_in[0] = in_dividend;
   assign quo_in[0] = '0;

   genvar k;
   generate
      for (k = 1; k < NST; k++) begin : g_step
         logic [tanh_pkg::REM_W-1:0] trial;
         always_comb begin
            trial     = tanh_pkg::REM_W'(div_ff[k-1]) << (tanh_pkg::QUO_W - k);
            rem_in[k] = rem_ff[k-1];
            quo_in[k] = quo_ff[k-1];
            if (rem_ff[k-1] >= trial) begin
               rem_in[k] = rem_ff[k-1] - trial;
               quo_in[k][tanh_pkg::QUO_W-k] = 1'b1;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         div_ff[0] <= in_divisor;
         ovf_ff[0] <= ovf_in;
         tag_ff[0] <= in_tag;
         for (int i = 1; i < NST; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            div_ff[i] <= div_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_quo   = quo_ff[NST-1];
   assign out_ovf   = ovf_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];

endmodule
`default_nettype wire

// ===== hdl/tanh_activation_unit_core.sv =====
// tanh activation unit: pade tanh and derivative, fully pipelined
// pipeline from req beat to rsp beat: 7 front stages, 17 divider stages,
// squaring stage and output register; throughput one beat per cycle unless held
// the whole pipeline holds while rsp_valid is high and rsp_ready low
// reset empties the pipeline and sets mode to tanh and the threshold to 20070
`default_nettype none
module tanh_activation_unit_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [15:0]            req_x_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [15:0]           rsp_y_value,
   output logic                         rsp_clamped,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire [2:0]                    csr_paddr,
   input  wire [31:0]                   csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [tanh_pkg::MODE_W-1:0] mode_ff;
   logic [tanh_pkg::THR_W-1:0]  thr_ff;
   logic                        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tanh_pkg::MODE_TANH;
         thr_ff  <= tanh_pkg::THR_RESET;
      end else if (wr_en) begin
         if (csr_paddr == tanh_pkg::ADDR_MODE) mode_ff <= csr_pwdata[1:0];
         if (csr_paddr == tanh_pkg::ADDR_THR)  thr_ff  <= csr_pwdata[14:0];
      end
   end

   always_comb begin
      case (csr_paddr)
         tanh_pkg::ADDR_MODE: csr_prdata = 32'(mode_ff);
         tanh_pkg::ADDR_THR:  csr_prdata = 32'(thr_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // global advance: pipeline moves unless the output beat is stuck
   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // front stages
   logic [6:0] v_ff;
   tanh_pkg::tag_type               tag_ff [7];
   logic [tanh_pkg::MAG_W-1:0]      mag_ff [5];
   logic [tanh_pkg::S_W-1:0]        s_ff   [2];
   logic [tanh_pkg::Q_W-1:0]        q_ff;
   logic [tanh_pkg::C_W-1:0]        c_ff;
   logic [tanh_pkg::NUM_W-1:0]      ns_ff, num_ff;
   logic [tanh_pkg::DEN_W-1:0]      ds_ff, den_ff [2];
   logic [tanh_pkg::PROD_W-1:0]     prod_ff;
   logic [tanh_pkg::REM_W-1:0]      a_ff;
   logic [tanh_pkg::DIVR_W-1:0]     b_ff;

   tanh_pkg::tag_type               tag_in;
   logic [tanh_pkg::MAG_W-1:0]      mag_in;

   always_comb begin
      mag_in = req_x_value[15] ? tanh_pkg::MAG_W'(-$signed({req_x_value[15], req_x_value}))
                               : tanh_pkg::MAG_W'(req_x_value);
      tag_in.mode   = mode_ff;
      tag_in.neg    = req_x_value[15];
      tag_in.forced = mag_in >= tanh_pkg::MAG_W'(thr_ff);
      tag_in.xzero  = (req_x_value == '0);
      tag_in.x      = req_x_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= tag_in;
         mag_ff[0] <= mag_in;
         for (int i = 1; i < 7; i++) tag_ff[i] <= tag_ff[i-1];
         for (int i = 1; i < 5; i++) mag_ff[i] <= mag_ff[i-1];
         // x^2
         s_ff[0] <= tanh_pkg::S_W'((2*tanh_pkg::MAG_W)'(mag_ff[0] * mag_ff[0]) >> 8);
         // x^4
         q_ff    <= tanh_pkg::Q_W'((2*tanh_pkg::S_W)'(s_ff[0] * s_ff[0]) >> 16);
         s_ff[1] <= s_ff[0];
         // x^6 and the constant-weighted x^2, x^4 terms
         c_ff  <= tanh_pkg::C_W'((tanh_pkg::Q_W+tanh_pkg::S_W)'(q_ff * s_ff[1]) >> 16);
         ns_ff <= tanh_pkg::NUM_W'(tanh_pkg::NUM_W'(s_ff[1]) * tanh_pkg::PADE_N2)
                + tanh_pkg::NUM_W'(tanh_pkg::NUM_W'(q_ff) * tanh_pkg::PADE_N4);
         ds_ff <= tanh_pkg::DEN_W'(tanh_pkg::DEN_W'(s_ff[1]) * tanh_pkg::PADE_D2)
                + tanh_pkg::DEN_W'(tanh_pkg::DEN_W'(q_ff) * tanh_pkg::PADE_D4);
         num_ff    <= tanh_pkg::PADE_K0 + ns_ff + tanh_pkg::NUM_W'(c_ff);
         den_ff[0] <= tanh_pkg::DEN_W'(tanh_pkg::PADE_K0) + ds_ff
                    + tanh_pkg::DEN_W'(tanh_pkg::DEN_W'(c_ff) * tanh_pkg::PADE_D6);
         prod_ff   <= tanh_pkg::PROD_W'(mag_ff[4]) * tanh_pkg::PROD_W'(num_ff);
         den_ff[1] <= den_ff[0];
         // round half up: (8*m*N + D) / (2*D)
         a_ff <= (tanh_pkg::REM_W'(prod_ff) << 3) + tanh_pkg::REM_W'(den_ff[1]);
         b_ff <= {den_ff[1], 1'b0};
      end
   end

   logic                            dv_valid;
   logic [tanh_pkg::QUO_W-1:0]      dv_quo;
   logic                            dv_ovf;
   tanh_pkg::tag_type               dv_tag;

   tanh_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (v_ff[6]),
      .in_dividend (a_ff),
      .in_divisor  (b_ff),
      .in_tag      (tag_ff[6]),
      .out_valid   (dv_valid),
      .out_quo     (dv_quo),
      .out_ovf     (dv_ovf),
      .out_tag     (dv_tag)
   );

   // squaring stage
   logic [tanh_pkg::R_W-1:0]        r_mag;
   logic signed [15:0]              t_in, op_in;
   logic signed [31:0]              sqp;
   logic [31:0]                     sqr;
   logic                            e_v_ff;
   logic signed [15:0]              t_ff;
   logic [tanh_pkg::SQ_W-1:0]       sq_ff;
   tanh_pkg::tag_type               e_tag_ff;

   always_comb begin
      if (dv_ovf || dv_quo > tanh_pkg::QUO_W'(tanh_pkg::ONE_Q14))
         r_mag = tanh_pkg::ONE_Q14;
      else
         r_mag = dv_quo[tanh_pkg::R_W-1:0];
      t_in  = dv_tag.neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
      op_in = (dv_tag.mode == tanh_pkg::MODE_DERIV_V) ? dv_tag.x : t_in;
      sqp   = op_in * op_in;
      sqr   = unsigned'(sqp) + 32'd8192;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff     <= t_in;
         sq_ff    <= sqr[14 +: tanh_pkg::SQ_W];
         e_tag_ff <= dv_tag;
      end
   end

   // result selection into the output register
   logic signed [17:0]  diff;
   logic signed [15:0]  oms;
   logic signed [15:0]  y_in;
   logic                cl_in;
   logic                out_v_ff;
   logic signed [15:0]  y_ff;
   logic                cl_ff;

   always_comb begin
      diff = 18'sd16384 - $signed({1'b0, sq_ff});
      oms  = (diff < -18'sd16384) ? -16'sd16384 : diff[15:0];
      y_in  = '0;
      cl_in = 1'b0;
      case (e_tag_ff.mode)
         tanh_pkg::MODE_TANH: begin
            cl_in = e_tag_ff.forced;
            if (e_tag_ff.forced) y_in = e_tag_ff.neg ? -16'sd16384 : 16'sd16384;
            else                 y_in = t_ff;
         end
         tanh_pkg::MODE_DERIV_X: begin
            if (e_tag_ff.xzero) begin
               y_in = 16'sd16384;
            end else if (e_tag_ff.forced) begin
               cl_in = 1'b1;
            end else begin
               y_in = oms;
            end
         end
         tanh_pkg::MODE_DERIV_V: y_in = oms;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff  <= y_in;
         cl_ff <= cl_in;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_y_value = y_ff;
   assign rsp_clamped = cl_ff;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the tanh activation unit core
`default_nettype none
module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_x_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_y_value;
   logic rsp_clamped;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   typedef struct packed {
      logic signed [15:0] y;
      logic clamped;
   } act_result_type;

   logic signed [15:0] sample_q[$];
   act_result_type result_q[$];
   logic [1:0] cur_mode = tanh_pkg::MODE_TANH;
   logic [14:0] cur_thr = tanh_pkg::THR_RESET;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   longint cycles = 0;

   tanh_activation_unit_core uut (.*);

   always #1 clock = ~clock;

   // tanh in q1.14 from q3.12; forced set when the threshold decides
   function automatic logic signed [15:0] tanh_q14(input logic signed [15:0] x,
                                                   input logic [14:0] thr,
                                                   output logic forced);
      logic [63:0] mag, s, q, c, num, den, r;
      mag = (x < 0) ? 64'(-32'(x)) : 64'(x);
      forced = 1'b0;
      if (mag >= 64'(thr)) begin
         forced = 1'b1;
         return (x < 0) ? -16'sd16384 : 16'sd16384;
      end
      s = (mag * mag) >> 8;
      q = (s * s) >> 16;
      c = (q * s) >> 16;
      num = (64'd135135 << 16) + 64'd17325 * s + 64'd378 * q + c;
      den = (64'd135135 << 16) + 64'd62370 * s + 64'd3150 * q + 64'd28 * c;
      r = (mag * num * 8 + den) / (den * 2);
      if (r > 64'd16384) r = 64'd16384;
      return (x < 0) ? -16'(r) : 16'(r);
   endfunction

   function automatic logic signed [15:0] one_minus_sq(input logic signed [15:0] t);
      longint sq, r;
      sq = (longint'(t) * longint'(t) + 8192) >>> 14;
      r = 16384 - sq;
      if (r < -16384) r = -16384;
      return 16'(r);
   endfunction

   function automatic act_result_type predict_activation(input logic signed [15:0] x);
      act_result_type res;
      logic f;
      logic signed [15:0] t;
      res = '0;
      case (cur_mode)
         tanh_pkg::MODE_TANH: begin
            res.y = tanh_q14(x, cur_thr, f);
            res.clamped = f;
         end
         tanh_pkg::MODE_DERIV_X: begin
            if (x == 0) res.y = 16'sd16384;
            else begin
               t = tanh_q14(x, cur_thr, f);
               res.y = f ? 16'sd0 : one_minus_sq(t);
               res.clamped = f;
            end
         end
         tanh_pkg::MODE_DERIV_V: res.y = one_minus_sq(x);
         default: res = '0;
      endcase
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_x_value <= sample_q[0];
               result_q.push_back(predict_activation(sample_q[0]));
               void'(sample_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      act_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_q.size() == 0) begin
            $display("%0t: unexpected result y=%0d clamped=%0b", $time, rsp_y_value,
                     rsp_clamped);
            errors = errors + 1;
         end else begin
            exp_res = result_q.pop_front();
            if (rsp_y_value !== exp_res.y) begin
               $display("%0t: y_value expected %0d actual %0d", $time, exp_res.y,
                        rsp_y_value);
               errors = errors + 1;
            end
            if (rsp_clamped !== exp_res.clamped) begin
               $display("%0t: clamped expected %0b actual %0b", $time, exp_res.clamped,
                        rsp_clamped);
               errors = errors + 1;
            end
         end
      end
      if (cycles > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == tanh_pkg::ADDR_MODE) cur_mode = data[1:0];
      else cur_thr = data[14:0];
   endtask

   task automatic drain();
      while (sample_q.size() != 0 || result_q.size() != 0 || req_valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'($urandom_range(65535));
         1: return 16'($urandom_range(300)) - 16'sd150;
         2: return cur_thr + 16'($urandom_range(4)) - 16'sd2;
         3: return -(cur_thr + 16'($urandom_range(4)) - 16'sd2);
         default: return 16'($urandom_range(40000)) - 16'sd20000;
      endcase
   endfunction

   initial begin
      int phase;
      logic [14:0] thr_set[6];
      logic [1:0] mode_set[6];
      thr_set = '{15'd20070, 15'd0, 15'd32767, 15'd8000, 15'd20070, 15'd1};
      mode_set = '{tanh_pkg::MODE_TANH, tanh_pkg::MODE_DERIV_X, tanh_pkg::MODE_DERIV_V,
                   tanh_pkg::MODE_TANH, tanh_pkg::MODE_DERIV_X, 2'd3};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // extremes and special cases under reset settings
      sample_q = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd20069,
                   16'sd20070, -16'sd20070, -16'sd20069, 16'sd4096, -16'sd4096,
                   16'sd16384, -16'sd16384, 16'sh5555, 16'shaaaa};
      drain();
      for (phase = 0; phase < 12; phase++) begin
         csr_write(tanh_pkg::ADDR_MODE, 32'(mode_set[phase % 6]));
         csr_write(tanh_pkg::ADDR_THR, 32'(thr_set[(phase + phase / 6) % 6]));
         send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 3) ? 31 : 63) : 0;
         recv_stall_pct = (phase % 4 == 2) ? 63 : ((phase % 4 == 3) ? 31 : 0);
         sample_q.push_back(16'sd0);
         sample_q.push_back(16'sh7fff);
         sample_q.push_back(-16'sh8000);
         repeat (70) sample_q.push_back(rand_sample());
         drain();
      end
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== tanh_activation_unit_core.f =====
hdl/tanh_pkg.sv
hdl/tanh_divider.sv
hdl/tanh_activation_unit_core.sv
verif/tb_top.sv
